[sv/hfa_pkg.sv]
// ----------------------------------------------------------------------------
// HLAC feature accumulator package
// Shared widths, mask factor tables and the queue item type.
// ----------------------------------------------------------------------------
package hfa_pkg;

  localparam int unsigned NUM_MASKS = 35;
  localparam int unsigned NUM_POS   = 9;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned TERM_W    = 9;
  localparam int unsigned SUM_W     = 43;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned ORD_W     = 2;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CIDX_W    = 2;
  localparam int unsigned ROW_W     = 8;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned P1_W      = 2 * TERM_W;
  localparam int unsigned P2_W      = 3 * TERM_W;

  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] CFG_RESET_VAL = 9'd64;
  localparam logic [CFG_W-1:0] DIM_MIN       = 9'd3;
  localparam logic [CFG_W-1:0] HEIGHT_MAX    = 9'd256;

  localparam logic [TERM_W-1:0] TERM_BASE = 9'd255;

  // A slot code of FACTOR_ONE stands for a factor of one.
  localparam logic [SLOT_W-1:0] FACTOR_ONE = 4'd9;

  localparam logic [SLOT_W-1:0] MASK_SLOT [NUM_MASKS][3] = '{
    '{4'd4, 4'd9, 4'd9}, '{4'd4, 4'd4, 4'd9}, '{4'd4, 4'd5, 4'd9},
    '{4'd2, 4'd4, 4'd9}, '{4'd1, 4'd4, 4'd9}, '{4'd0, 4'd4, 4'd9},
    '{4'd4, 4'd4, 4'd4}, '{4'd4, 4'd4, 4'd5}, '{4'd4, 4'd5, 4'd5},
    '{4'd2, 4'd4, 4'd4}, '{4'd2, 4'd2, 4'd4}, '{4'd1, 4'd4, 4'd4},
    '{4'd1, 4'd1, 4'd4}, '{4'd0, 4'd4, 4'd4}, '{4'd0, 4'd0, 4'd4},
    '{4'd3, 4'd4, 4'd5}, '{4'd2, 4'd4, 4'd6}, '{4'd1, 4'd4, 4'd7},
    '{4'd0, 4'd4, 4'd8}, '{4'd2, 4'd3, 4'd4}, '{4'd1, 4'd4, 4'd6},
    '{4'd0, 4'd4, 4'd7}, '{4'd3, 4'd4, 4'd8}, '{4'd4, 4'd5, 4'd6},
    '{4'd2, 4'd4, 4'd7}, '{4'd1, 4'd4, 4'd8}, '{4'd0, 4'd4, 4'd5},
    '{4'd1, 4'd3, 4'd4}, '{4'd0, 4'd4, 4'd6}, '{4'd3, 4'd4, 4'd7},
    '{4'd4, 4'd6, 4'd8}, '{4'd4, 4'd5, 4'd7}, '{4'd2, 4'd4, 4'd8},
    '{4'd1, 4'd4, 4'd5}, '{4'd0, 4'd2, 4'd4}
  };

  typedef logic [NUM_POS-1:0][TERM_W-1:0] hfa_terms_t;

  typedef struct packed {
    hfa_terms_t term;
    logic       frame_end;
  } hfa_item_t;

  function automatic logic [TERM_W-1:0] pick_factor(input logic [SLOT_W-1:0] code,
                                                    input hfa_terms_t terms);
    logic [TERM_W-1:0] f;
    if (code < FACTOR_ONE) begin
      f = terms[code];
    end else begin
      f = {{(TERM_W-1){1'b0}}, 1'b1};
    end
    return f;
  endfunction

  function automatic logic [ORD_W-1:0] mask_order(input logic [IDX_W-1:0] idx);
    logic [ORD_W-1:0] o;
    if (idx == 6'd0) begin
      o = 2'd1;
    end else if (idx <= 6'd5) begin
      o = 2'd2;
    end else begin
      o = 2'd3;
    end
    return o;
  endfunction

endpackage

[sv/hlac_feature_accumulator.sv]
// ----------------------------------------------------------------------------
// HLAC feature accumulator
// Gray-level 35-mask higher order local autocorrelation sums over a frame.
//
//   channel  direction  handshake              payload
//   input    in         in_valid_i/in_stall_o  gray_pixel_i
//   output   out        out_valid_o/out_stall_i mask_index_o, mask_order_o,
//                                              feature_sum_o, last_of_frame_o
//   config   in         cfg_we_i               cfg_index_i, cfg_data_i
//
// One pixel is taken per cycle while the four-entry term queue has room.
// A pixel passes stage s1, the term queue and stages b1 and b2 to the sums.
// At frame end the 35 sums leave one per cycle unless out_stall_i holds
// them; pixels keep entering the queue meanwhile until it fills.
// Reset and any register write restart the frame and clear the sums.
// ----------------------------------------------------------------------------
module hlac_feature_accumulator #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hfa_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [hfa_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hfa_pkg::PIX_W-1:0]    gray_pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hfa_pkg::IDX_W-1:0]    mask_index_o,
  output logic [hfa_pkg::ORD_W-1:0]    mask_order_o,
  output logic [hfa_pkg::SUM_W-1:0]    feature_sum_o,
  output logic                         last_of_frame_o
);
  import hfa_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW = (WW > CFG_W) ? WW : CFG_W;
  localparam int unsigned NW = $clog2(QDEPTH + 1);

  logic [CFG_W-1:0] width_q, height_q;
  logic [EW-1:0]    width_ext;
  logic [WW-1:0]    eff_width;
  logic [CFG_W-1:0] eff_height;
  logic             restart, accept, front_busy, push, pop, head_valid;
  hfa_item_t        push_item, head_item;
  logic [NW-1:0]    q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_RESET_VAL;
      height_q <= CFG_RESET_VAL;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_FRAME_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_FRAME_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  assign restart = cfg_we_i &&
                   ((cfg_index_i == CFG_FRAME_WIDTH) || (cfg_index_i == CFG_FRAME_HEIGHT));

  always_comb begin
    width_ext = EW'(width_q);
    if (width_q < DIM_MIN) begin
      width_ext = EW'(DIM_MIN);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      width_ext = EW'(MAX_WIDTH);
    end
    eff_width = width_ext[WW-1:0];
    eff_height = height_q;
    if (height_q < DIM_MIN) begin
      eff_height = DIM_MIN;
    end else if (height_q > HEIGHT_MAX) begin
      eff_height = HEIGHT_MAX;
    end
  end

  assign in_stall_o = (q_count + NW'(front_busy)) >= NW'(QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  hfa_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .eff_width_i (eff_width),
    .eff_height_i(eff_height),
    .accept_i    (accept),
    .pixel_i     (gray_pixel_i),
    .busy_o      (front_busy),
    .push_o      (push),
    .item_o      (push_item)
  );

  hfa_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .valid_o(head_valid),
    .item_o (head_item),
    .count_o(q_count)
  );

  hfa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (restart),
    .head_valid_i   (head_valid),
    .head_i         (head_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mask_index_o   (mask_index_o),
    .mask_order_o   (mask_order_o),
    .feature_sum_o  (feature_sum_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule

[sv/hfa_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/hfa_front.sv]
// ----------------------------------------------------------------------------
// HLAC front end
// Counts raster position, keeps the line stores and the 3x3 window, and
// turns each interior centre into nine border-masked terms.
// ----------------------------------------------------------------------------
module hfa_front #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              restart_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_width_i,
  input  logic [hfa_pkg::CFG_W-1:0]         eff_height_i,
  input  logic                              accept_i,
  input  logic [hfa_pkg::PIX_W-1:0]         pixel_i,
  output logic                              busy_o,
  output logic                              push_o,
  output hfa_pkg::hfa_item_t                item_o
);
  import hfa_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  typedef struct packed {
    logic acc;
    logic frame_end;
    logic row_top;
    logic row_bot;
    logic col_left;
    logic col_right;
  } hfa_pos_t;

  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_col_q;
  hfa_pos_t         s1_pos_q, pos;
  logic [PIX_W-1:0] win_q [NUM_POS];
  logic [PIX_W-1:0] win_d [NUM_POS];
  logic [2*PIX_W-1:0] rd_data;
  logic             c_last, r_last;
  logic [2:0]       row_ok, col_ok;

  assign c_last = ({{(WW-CW){1'b0}}, col_q} == (eff_width_i - WW'(1)));
  assign r_last = ({1'b0, row_q} == (eff_height_i - CFG_W'(1)));

  always_comb begin
    pos.acc       = (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
    pos.frame_end = c_last && r_last;
    pos.row_top   = row_q >= ROW_W'(3);
    pos.row_bot   = !r_last;
    pos.col_left  = col_q >= CW'(3);
    pos.col_right = !c_last;
    col_d = c_last ? '0 : col_q + CW'(1);
    row_d = row_q;
    if (c_last) begin
      row_d = r_last ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
      if (restart_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_pix_q <= pixel_i;
      s1_col_q <= col_q;
      s1_pos_q <= pos;
    end
    if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  hfa_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_col_q),
    .wdata_i({rd_data[PIX_W-1:0], s1_pix_q}),
    .re_i   (accept_i),
    .raddr_i(col_q),
    .rdata_o(rd_data)
  );

  always_comb begin
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = rd_data[2*PIX_W-1:PIX_W];
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = rd_data[PIX_W-1:0];
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s1_pix_q;
    row_ok = {s1_pos_q.row_bot, 1'b1, s1_pos_q.row_top};
    col_ok = {s1_pos_q.col_right, 1'b1, s1_pos_q.col_left};
    for (int z = 0; z < NUM_POS; z++) begin
      if (row_ok[z / 3] && col_ok[z % 3]) begin
        item_o.term[z] = TERM_BASE + {1'b0, win_d[z]};
      end else begin
        item_o.term[z] = TERM_BASE;
      end
    end
    item_o.frame_end = s1_pos_q.frame_end;
  end

  assign push_o = s1_valid_q && s1_pos_q.acc;
  assign busy_o = s1_valid_q;

endmodule

[sv/hfa_queue.sv]
// ----------------------------------------------------------------------------
// HLAC term queue
// Short FIFO of term sets between the front end and the product back end.
// ----------------------------------------------------------------------------
module hfa_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  hfa_pkg::hfa_item_t                  item_i,
  input  logic                                pop_i,
  output logic                                valid_o,
  output hfa_pkg::hfa_item_t                  item_o,
  output logic [$clog2(hfa_pkg::QDEPTH+1)-1:0] count_o
);
  import hfa_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned NW = $clog2(QDEPTH + 1);

  hfa_item_t      slot_q [QDEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [NW-1:0]  cnt_q, cnt_d;
  logic           do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign item_o  = slot_q[rd_q];
  assign count_o = cnt_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !do_pop && (cnt_q == NW'(QDEPTH))))
    else $error("term queue written while full");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> (cnt_q == $past(cnt_q) + NW'(1)))
    else $error("term queue count did not follow a write");
`endif

endmodule

[sv/hfa_back.sv]
// ----------------------------------------------------------------------------
// HLAC back end
// Forms the 35 mask products in a two-multiply pipeline, accumulates them
// per frame and reads the sums out one at a time at frame end.
// ----------------------------------------------------------------------------
module hfa_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         restart_i,
  input  logic                         head_valid_i,
  input  hfa_pkg::hfa_item_t           head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hfa_pkg::IDX_W-1:0]    mask_index_o,
  output logic [hfa_pkg::ORD_W-1:0]    mask_order_o,
  output logic [hfa_pkg::SUM_W-1:0]    feature_sum_o,
  output logic                         last_of_frame_o
);
  import hfa_pkg::*;

  logic                b1_valid_q, b1_end_q;
  logic [P1_W-1:0]     b1_prod_q [NUM_MASKS];
  logic [TERM_W-1:0]   b1_f2_q   [NUM_MASKS];
  logic                b2_valid_q, b2_end_q;
  logic [P2_W-1:0]     b2_prod_q [NUM_MASKS];
  logic [SUM_W-1:0]    sum_q     [NUM_MASKS];
  logic                emit_q;
  logic [IDX_W-1:0]    idx_q;
  logic                out_valid_q, out_last_q;
  logic [IDX_W-1:0]    out_index_q;
  logic [ORD_W-1:0]    out_order_q;
  logic [SUM_W-1:0]    out_sum_q;
  logic                advance, emit_step, acc_step;

  assign advance   = !emit_q;
  assign pop_o     = head_valid_i && advance;
  assign emit_step = emit_q && (!out_valid_q || !out_stall_i);
  assign acc_step  = b2_valid_q && advance;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int k = 0; k < NUM_MASKS; k++) begin
        b1_prod_q[k] <= pick_factor(MASK_SLOT[k][0], head_i.term)
                      * pick_factor(MASK_SLOT[k][1], head_i.term);
        b1_f2_q[k]   <= pick_factor(MASK_SLOT[k][2], head_i.term);
        b2_prod_q[k] <= {{(P2_W-P1_W){1'b0}}, b1_prod_q[k]}
                      * {{(P2_W-TERM_W){1'b0}}, b1_f2_q[k]};
      end
      b1_end_q <= head_i.frame_end;
      b2_end_q <= b1_end_q;
    end
    if (emit_step) begin
      out_index_q <= idx_q;
      out_order_q <= mask_order(idx_q);
      out_sum_q   <= sum_q[0];
      out_last_q  <= idx_q == IDX_W'(NUM_MASKS - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      emit_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_MASKS; k++) begin
        sum_q[k] <= '0;
      end
    end else begin
      if (advance) begin
        b1_valid_q <= head_valid_i;
        b2_valid_q <= b1_valid_q;
      end
      if (restart_i) begin
        for (int k = 0; k < NUM_MASKS; k++) begin
          sum_q[k] <= '0;
        end
      end else if (acc_step) begin
        for (int k = 0; k < NUM_MASKS; k++) begin
          sum_q[k] <= sum_q[k] + {{(SUM_W-P2_W){1'b0}}, b2_prod_q[k]};
        end
        if (b2_end_q) begin
          emit_q <= 1'b1;
          idx_q  <= '0;
        end
      end else if (emit_step) begin
        for (int k = 0; k < NUM_MASKS - 1; k++) begin
          sum_q[k] <= sum_q[k+1];
        end
        sum_q[NUM_MASKS-1] <= '0;
        if (idx_q == IDX_W'(NUM_MASKS - 1)) begin
          emit_q <= 1'b0;
          idx_q  <= '0;
        end else begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      if (emit_step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mask_index_o    = out_index_q;
  assign mask_order_o    = out_order_q;
  assign feature_sum_o   = out_sum_q;
  assign last_of_frame_o = out_last_q;

`ifndef SYNTHESIS
  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> (idx_q <= IDX_W'(NUM_MASKS - 1)))
    else $error("readout index past the last mask");

  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_step && (idx_q == IDX_W'(NUM_MASKS - 1))) |=> (!emit_q && out_last_q))
    else $error("readout did not close on the last mask");
`endif

endmodule
